/* rtl/sbid_pkg.sv */
// ----------------------------------------------------------------------------
// Serial boot image deframer package
// Shared types and constants for the deframer front, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sbid_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam logic [31:0] MAGIC_RESET = 32'h544F4F42;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SIZE = 2'd1,
    PH_LOAD = 2'd2
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOAD_BASE = 2'd0,
    REG_MAGIC     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] index;
    logic [7:0]  data;
    logic [31:0] size;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/sbid_rx_if.sv */
// ----------------------------------------------------------------------------
// Received byte channel
// Carries one serial byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbid_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/sbid_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Carries header results and payload memory writes with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbid_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic [31:0] image_size;
  logic        last;

  modport source (output valid, output kind, output write_address, output write_data,
                  output image_size, output last, input ready);
  modport sink (input valid, input kind, input write_address, input write_data,
                input image_size, input last, output ready);
endinterface

`default_nettype wire

/* rtl/sbid_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbid_cfg_if;
  import sbid_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [31:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/serial_boot_image_deframer.sv */
// ----------------------------------------------------------------------------
// Serial boot image deframer
// Hunts for the magic word in aligned little-endian groups, takes the image
// size and issues one memory write per payload byte.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// rx       sink       rx_byte
// result   source     kind, write_address, write_data, image_size, last
// cfg      sink       index, data (load base address, magic word)
//
// One byte is accepted every cycle while the command queue has room; a result
// passes from the front through a two-entry command queue into the output
// register, which holds it until its sink takes it.
// The front stalls only when that queue is full, the back end only when the
// result register is held by its sink. Synchronous reset returns to hunting.
// Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_boot_image_deframer #(
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  sbid_rx_if.sink       rx,
  sbid_result_if.source result,
  sbid_cfg_if.sink      cfg
);
  import sbid_pkg::*;

  logic [31:0] load_base_address;
  logic [31:0] magic_word;
  cmd_t        push_cmd;
  logic        push;
  cmd_t        head;
  logic        pop;
  q_status_t   q_status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base_address <= '0;
      magic_word        <= MAGIC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LOAD_BASE: load_base_address <= cfg.data;
        REG_MAGIC:     magic_word        <= cfg.data;
        default:       ;
      endcase
    end
  end

  sbid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .magic_word (magic_word),
    .q_status   (q_status),
    .cmd        (push_cmd),
    .cmd_push   (push)
  );

  sbid_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cmd (push_cmd),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sbid_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .q_status          (q_status),
    .load_base_address (load_base_address),
    .pop               (pop),
    .result            (result)
  );

`ifndef ASSERT_OFF
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.kind |-> (result.last == (result.image_size == 32'd0)))
    else $error("header last flag does not match zero image size");

  a_header_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.kind |-> (result.write_address == 32'd0 &&
                                      result.write_data == 8'd0))
    else $error("header result carries address or data");

  a_reset_idle: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

/* rtl/sbid_front.sv */
// ----------------------------------------------------------------------------
// Deframer front
// Accepts bytes, hunts for the magic word, collects the size and issues
// header and payload commands into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbid_front (
  input  wire logic              clk,
  input  wire logic              rst,
  sbid_rx_if.sink                rx,
  input  wire logic [31:0]       magic_word,
  input  wire sbid_pkg::q_status_t q_status,
  output sbid_pkg::cmd_t         cmd,
  output logic                   cmd_push
);
  import sbid_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [31:0] word, word_next;
  logic [31:0] size, size_next;
  logic [31:0] index, index_next;
  logic        accept;
  logic [31:0] full_word;

  assign rx.ready  = !q_status.full;
  assign accept    = rx.valid && rx.ready;
  assign full_word = {rx.rx_byte, word[23:0]};

  always_comb begin
    phase_next    = phase;
    byte_pos_next = byte_pos;
    word_next     = word;
    size_next     = size;
    index_next    = index;
    if (accept) begin
      unique case (phase)
        PH_LOAD: begin
          if (index == size - 32'd1) begin
            phase_next = PH_HUNT;
            size_next  = '0;
            index_next = '0;
          end else begin
            index_next = index + 32'd1;
          end
        end
        PH_SIZE: begin
          if (byte_pos != 2'd3) begin
            word_next[{byte_pos, 3'b000} +: 8] = rx.rx_byte;
            byte_pos_next = byte_pos + 2'd1;
          end else begin
            byte_pos_next = '0;
            word_next     = '0;
            index_next    = '0;
            if (full_word == 32'd0) begin
              phase_next = PH_HUNT;
              size_next  = '0;
            end else begin
              phase_next = PH_LOAD;
              size_next  = full_word;
            end
          end
        end
        default: begin
          if (byte_pos != 2'd3) begin
            word_next[{byte_pos, 3'b000} +: 8] = rx.rx_byte;
            byte_pos_next = byte_pos + 2'd1;
          end else begin
            byte_pos_next = '0;
            word_next     = '0;
            phase_next    = (full_word == magic_word) ? PH_SIZE : PH_HUNT;
          end
        end
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd_push = 1'b0;
    unique case (phase)
      PH_LOAD: begin
        cmd_push  = accept;
        cmd.kind  = 1'b1;
        cmd.index = index;
        cmd.data  = rx.rx_byte;
        cmd.size  = size;
        cmd.last  = (index == size - 32'd1);
      end
      PH_SIZE: begin
        cmd_push = accept && (byte_pos == 2'd3);
        cmd.size = full_word;
        cmd.last = (full_word == 32'd0);
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      byte_pos <= '0;
      word     <= '0;
      size     <= '0;
      index    <= '0;
    end else begin
      phase    <= phase_next;
      byte_pos <= byte_pos_next;
      word     <= word_next;
      size     <= size_next;
      index    <= index_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/sbid_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the deframer front from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbid_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sbid_pkg::cmd_t  push_cmd,
  input  wire logic            push,
  input  wire logic            pop,
  output sbid_pkg::cmd_t       head,
  output sbid_pkg::q_status_t  status
);
  import sbid_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/sbid_back.sv */
// ----------------------------------------------------------------------------
// Deframer back end
// Forms the write address for each payload command and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbid_back #(
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sbid_pkg::cmd_t      head,
  input  wire sbid_pkg::q_status_t q_status,
  input  wire logic [31:0]         load_base_address,
  output logic                     pop,
  sbid_result_if.source            result
);
  import sbid_pkg::*;

  localparam logic [63:0] AddrMask64 = {64{1'b1}} >> (64 - ADDR_WIDTH);
  localparam logic [31:0] AddrMask   = AddrMask64[31:0];

  logic [31:0] sum;

  assign sum = (load_base_address + head.index) & AddrMask;
  assign pop = !q_status.empty && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      result.kind          <= head.kind;
      result.write_address <= head.kind ? sum : 32'd0;
      result.write_data    <= head.data;
      result.image_size    <= head.size;
      result.last          <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
